### rtl/core/gfd_pkg.sv
// ----------------------------------------------------------------------------
// gfd_pkg: shared types and constants for the flat-earth distance pipeline
// Field widths, fixed-point formats, polynomial coefficients and latencies.
// ----------------------------------------------------------------------------
`default_nettype none

package gfd_pkg;

	// Fixed-point formats (fractional bits)
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int LAT_Q           = 16;
	localparam int COEF_Q          = 36;
	localparam int SCALE_Q         = 20;
	localparam int COMP_Q          = 12;
	localparam int OUT_Q           = 8;

	// Port field widths
	localparam int LON_W  = 25;
	localparam int LAT_W  = 24;
	localparam int DIST_W = 24;

	// Coordinate differences and their magnitudes
	localparam int DLON_W = LON_W + 1;
	localparam int DLAT_W = LAT_W + 1;

	// Mean latitude, degrees in LAT_Q, clamped to the poles
	localparam int LAT_SUM_W = LAT_W + 1;
	localparam int LAT_SH    = ANGLE_FRAC_BITS + 1 - LAT_Q;
	localparam int LAT_HALF  = 1 << (LAT_SH - 1);
	localparam int MLAT_W    = 24;
	localparam int LAT_LIMIT = 90 * (1 << LAT_Q);

	// Polynomial lanes
	localparam int LANES    = 2;
	localparam int LANE_LON = 0;
	localparam int LANE_LAT = 1;

	// Horner accumulator and product widths
	localparam int C3_W   = 18;
	localparam int A2_W   = 27;
	localparam int A1_W   = 34;
	localparam int A0_W   = 41;
	localparam int P3_W   = C3_W + MLAT_W;
	localparam int P2_W   = A2_W + MLAT_W;
	localparam int PROD_W = A1_W + MLAT_W;

	localparam logic signed [A0_W-1:0] COEF0 [LANES] = '{41'sd126492490584, 41'sd126677758293};
	localparam logic signed [A1_W-1:0] COEF1 [LANES] = '{34'sd104927769, -34'sd4767750};
	localparam logic signed [A2_W-1:0] COEF2 [LANES] = '{-27'sd23364622, 27'sd604727};
	localparam logic signed [C3_W-1:0] COEF3 [LANES] = '{18'sd70325, -18'sd4450};

	// Scale factor magnitude in SCALE_Q
	localparam int SCALE_W  = 24;
	localparam int SCALE_SH = COEF_Q - SCALE_Q;
	localparam int HORN_LAT = 7;

	// Components in km, COMP_Q, clamped at 2^16 km
	localparam int COMP_KM_BITS = 16;
	localparam int Q_W          = SCALE_W + LON_W;
	localparam int P60_W        = Q_W + 6;
	localparam int COMP_SH      = SCALE_Q + ANGLE_FRAC_BITS - COMP_Q;
	localparam int COMP_W       = COMP_KM_BITS + COMP_Q + 1;
	localparam longint unsigned COMP_LIMIT = 64'd1 << (COMP_KM_BITS + COMP_Q);

	// Square root
	localparam int RAD_W  = 2 * COMP_W;
	localparam int ROOT_W = COMP_W;
	localparam int REM_W  = ROOT_W + 3;
	localparam int OUT_SH = COMP_Q - OUT_Q;
	localparam longint unsigned OUT_MAX = (64'd1 << DIST_W) - 64'd1;

	// Input stage, Horner, component product, clamp, square, sum, root, output
	localparam int GFD_LAT = 1 + HORN_LAT + 4 + ROOT_W + 1;

	// Signed round to nearest of a LAT_Q product, ties away from zero
	function automatic logic signed [PROD_W-1:0] round_q16(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-1:0] m;
		logic [PROD_W-1:0] r;
		m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		r = (m + (PROD_W'(1) << (LAT_Q - 1))) >> LAT_Q;
		return v[PROD_W-1] ? -$signed(r) : $signed(r);
	endfunction

endpackage

`default_nettype wire

### rtl/core/geographic_flat_distance.sv
// ----------------------------------------------------------------------------
// geographic_flat_distance: planar event-to-station distance
// Fixed-point flat-earth distance with latitude-dependent km scale factors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: raise start with event_lon, event_lat, station_lon and
//   station_lat (degrees, 16 fractional bits). A transfer happens at each
//   rising edge with start high and busy low. busy is held low: the block is a
//   fully pipelined datapath and takes a new transfer in every cycle.
//   Result channel: done pulses for one cycle with distance_km (km, 8
//   fractional bits, saturated at all ones). The receiver takes it in that
//   cycle; there is no back-pressure, so nothing in the pipeline ever stalls.
//   Pipeline: 1 input stage, 7 Horner stages (three multiply/round-add pairs
//   and a scale round), 4 stages for component product, x60 with rounding
//   and clamp, squaring and sum, 29 square-root stages (one root bit each)
//   and an output round/saturate stage.
//   Throughput: one item per cycle, results in acceptance order.
//   Reset: arst_n clears all valid bits at once; items in flight are dropped
//   and no done is raised until a new transfer has passed through.
// ----------------------------------------------------------------------------
`default_nettype none

module geographic_flat_distance (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [gfd_pkg::LON_W-1:0]     event_lon,
	input  wire logic signed [gfd_pkg::LAT_W-1:0]     event_lat,
	input  wire logic signed [gfd_pkg::LON_W-1:0]     station_lon,
	input  wire logic signed [gfd_pkg::LAT_W-1:0]     station_lat,
	output logic                                      done,
	output logic             [gfd_pkg::DIST_W-1:0]    distance_km
);

	// |scale| * |diff| * 60, rounded to COMP_Q and clamped at 2^16 km
	function automatic logic [gfd_pkg::COMP_W-1:0] comp_km(input logic [gfd_pkg::Q_W-1:0] q);
		logic [gfd_pkg::P60_W-1:0] p;
		logic [gfd_pkg::P60_W-1:0] c;
		// times 60 as 64 - 4
		p = (gfd_pkg::P60_W'(q) << 6) - (gfd_pkg::P60_W'(q) << 2);
		c = (p + (gfd_pkg::P60_W'(1) << (gfd_pkg::COMP_SH - 1))) >> gfd_pkg::COMP_SH;
		return (c > gfd_pkg::P60_W'(gfd_pkg::COMP_LIMIT)) ? gfd_pkg::COMP_W'(gfd_pkg::COMP_LIMIT)
			: gfd_pkg::COMP_W'(c);
	endfunction

	logic take;

	// Stage 1 inputs: mean latitude and difference magnitudes
	logic signed [gfd_pkg::LAT_SUM_W-1:0] lat_sum;
	logic        [gfd_pkg::LAT_SUM_W-1:0] lat_mag;
	logic        [gfd_pkg::LAT_SUM_W:0]   lat_rnd;
	logic        [gfd_pkg::MLAT_W-1:0]    lat_clip;
	logic signed [gfd_pkg::MLAT_W-1:0]    lat_mean;
	logic signed [gfd_pkg::DLON_W-1:0]    dlon;
	logic signed [gfd_pkg::DLAT_W-1:0]    dlat;
	logic        [gfd_pkg::LON_W-1:0]     dlon_mag;
	logic        [gfd_pkg::LAT_W-1:0]     dlat_mag;

	logic                                 vld_s1;
	logic signed [gfd_pkg::MLAT_W-1:0]    lat_s1;
	logic        [gfd_pkg::LON_W-1:0]     dlon_s1;
	logic        [gfd_pkg::LAT_W-1:0]     dlat_s1;

	// Difference line that runs beside the Horner pipeline
	logic        [gfd_pkg::LON_W-1:0]     dlon_dly [gfd_pkg::HORN_LAT];
	logic        [gfd_pkg::LAT_W-1:0]     dlat_dly [gfd_pkg::HORN_LAT];

	logic                                 vld_s8;
	logic        [gfd_pkg::SCALE_W-1:0]   scale_s8 [gfd_pkg::LANES];

	logic                                 vld_s9, vld_s10, vld_s11, vld_s12;
	logic        [gfd_pkg::Q_W-1:0]       qlon_s9, qlat_s9;
	logic        [gfd_pkg::COMP_W-1:0]    x_s10, y_s10;
	logic        [gfd_pkg::RAD_W-1:0]     xx_s11, yy_s11;
	logic        [gfd_pkg::RAD_W-1:0]     rad_s12;

	logic                                 vld_s41;
	logic        [gfd_pkg::ROOT_W-1:0]    root_s41;
	logic        [gfd_pkg::ROOT_W:0]      dist_rnd;

	logic                                 done_q;
	logic        [gfd_pkg::DIST_W-1:0]    dist_q;

	// Never back-pressure: the pipeline advances every cycle
	assign busy = 1'b0;
	assign take = start && !busy;

	// Mean latitude: halve the exact sum with round-half-away, clamp at the poles
	always_comb begin
		lat_sum  = gfd_pkg::LAT_SUM_W'(event_lat) + gfd_pkg::LAT_SUM_W'(station_lat);
		lat_mag  = lat_sum[gfd_pkg::LAT_SUM_W-1] ? gfd_pkg::LAT_SUM_W'(-lat_sum)
			: gfd_pkg::LAT_SUM_W'(lat_sum);
		lat_rnd  = ((gfd_pkg::LAT_SUM_W+1)'(lat_mag) + (gfd_pkg::LAT_SUM_W+1)'(gfd_pkg::LAT_HALF))
			>> gfd_pkg::LAT_SH;
		lat_clip = (lat_rnd > (gfd_pkg::LAT_SUM_W+1)'(gfd_pkg::LAT_LIMIT))
			? gfd_pkg::MLAT_W'(gfd_pkg::LAT_LIMIT) : gfd_pkg::MLAT_W'(lat_rnd);
		lat_mean = lat_sum[gfd_pkg::LAT_SUM_W-1] ? -$signed(lat_clip) : $signed(lat_clip);

		// plain differences, no wrap at 180 degrees
		dlon     = gfd_pkg::DLON_W'(station_lon) - gfd_pkg::DLON_W'(event_lon);
		dlat     = gfd_pkg::DLAT_W'(station_lat) - gfd_pkg::DLAT_W'(event_lat);
		dlon_mag = dlon[gfd_pkg::DLON_W-1] ? gfd_pkg::LON_W'(-dlon) : gfd_pkg::LON_W'(dlon);
		dlat_mag = dlat[gfd_pkg::DLAT_W-1] ? gfd_pkg::LAT_W'(-dlat) : gfd_pkg::LAT_W'(dlat);
	end

	gfd_horner u_horner (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.lat     (lat_s1),
		.out_vld (vld_s8),
		.scale   (scale_s8)
	);

	gfd_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s12),
		.rad     (rad_s12),
		.out_vld (vld_s41),
		.root    (root_s41)
	);

	// Round the root from COMP_Q to OUT_Q
	assign dist_rnd = ((gfd_pkg::ROOT_W+1)'(root_s41)
		+ (gfd_pkg::ROOT_W+1)'(1 << (gfd_pkg::OUT_SH - 1))) >> gfd_pkg::OUT_SH;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= take;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			done_q  <= vld_s41;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		lat_s1  <= lat_mean;
		dlon_s1 <= dlon_mag;
		dlat_s1 <= dlat_mag;

		dlon_dly[0] <= dlon_s1;
		dlat_dly[0] <= dlat_s1;
		for (int i = 1; i < gfd_pkg::HORN_LAT; i++) begin
			dlon_dly[i] <= dlon_dly[i-1];
			dlat_dly[i] <= dlat_dly[i-1];
		end

		// scale times difference magnitude
		qlon_s9 <= gfd_pkg::Q_W'(scale_s8[gfd_pkg::LANE_LON])
			* gfd_pkg::Q_W'(dlon_dly[gfd_pkg::HORN_LAT-1]);
		qlat_s9 <= gfd_pkg::Q_W'(scale_s8[gfd_pkg::LANE_LAT])
			* gfd_pkg::Q_W'(dlat_dly[gfd_pkg::HORN_LAT-1]);

		x_s10 <= comp_km(qlon_s9);
		y_s10 <= comp_km(qlat_s9);

		xx_s11 <= gfd_pkg::RAD_W'(x_s10) * gfd_pkg::RAD_W'(x_s10);
		yy_s11 <= gfd_pkg::RAD_W'(y_s10) * gfd_pkg::RAD_W'(y_s10);

		rad_s12 <= xx_s11 + yy_s11;

		// saturate at the field maximum
		dist_q <= (dist_rnd > (gfd_pkg::ROOT_W+1)'(gfd_pkg::OUT_MAX))
			? gfd_pkg::DIST_W'(gfd_pkg::OUT_MAX) : gfd_pkg::DIST_W'(dist_rnd);
	end

	assign done        = done_q;
	assign distance_km = dist_q;

endmodule

`default_nettype wire

### rtl/core/gfd_horner.sv
// ----------------------------------------------------------------------------
// gfd_horner: two-lane cubic evaluation in the mean latitude
// Horner steps alternate multiply and round-add stages; the last stage
// rounds the scale magnitude to SCALE_Q.
// ----------------------------------------------------------------------------
`default_nettype none

module gfd_horner (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_vld,
	input  wire logic signed [gfd_pkg::MLAT_W-1:0]       lat,
	output logic                                         out_vld,
	output logic             [gfd_pkg::SCALE_W-1:0]      scale [gfd_pkg::LANES]
);

	logic [gfd_pkg::HORN_LAT-1:0] vld_q;

	logic signed [gfd_pkg::MLAT_W-1:0] lat_s1, lat_s2, lat_s3, lat_s4;
	logic signed [gfd_pkg::P3_W-1:0]   p3_s1   [gfd_pkg::LANES];
	logic signed [gfd_pkg::A2_W-1:0]   acc2_s2 [gfd_pkg::LANES];
	logic signed [gfd_pkg::P2_W-1:0]   p2_s3   [gfd_pkg::LANES];
	logic signed [gfd_pkg::A1_W-1:0]   acc1_s4 [gfd_pkg::LANES];
	logic signed [gfd_pkg::PROD_W-1:0] p1_s5   [gfd_pkg::LANES];
	logic signed [gfd_pkg::A0_W-1:0]   acc0_s6 [gfd_pkg::LANES];
	logic        [gfd_pkg::SCALE_W-1:0] scale_s7 [gfd_pkg::LANES];
	logic        [gfd_pkg::A0_W-1:0]   mag0    [gfd_pkg::LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[gfd_pkg::HORN_LAT-2:0], in_vld};
		end
	end

	always_comb begin
		for (int l = 0; l < gfd_pkg::LANES; l++) begin
			mag0[l] = acc0_s6[l][gfd_pkg::A0_W-1] ? gfd_pkg::A0_W'(-acc0_s6[l])
				: gfd_pkg::A0_W'(acc0_s6[l]);
		end
	end

	always_ff @(posedge clk) begin
		lat_s1 <= lat;
		lat_s2 <= lat_s1;
		lat_s3 <= lat_s2;
		lat_s4 <= lat_s3;
		for (int l = 0; l < gfd_pkg::LANES; l++) begin
			p3_s1[l]   <= gfd_pkg::COEF3[l] * lat;
			acc2_s2[l] <= gfd_pkg::COEF2[l]
				+ gfd_pkg::A2_W'(gfd_pkg::round_q16(gfd_pkg::PROD_W'(p3_s1[l])));
			p2_s3[l]   <= acc2_s2[l] * lat_s2;
			acc1_s4[l] <= gfd_pkg::COEF1[l]
				+ gfd_pkg::A1_W'(gfd_pkg::round_q16(gfd_pkg::PROD_W'(p2_s3[l])));
			p1_s5[l]   <= acc1_s4[l] * lat_s4;
			acc0_s6[l] <= gfd_pkg::COEF0[l] + gfd_pkg::A0_W'(gfd_pkg::round_q16(p1_s5[l]));
			// drop the sign: each component is squared later
			scale_s7[l] <= gfd_pkg::SCALE_W'((mag0[l]
				+ (gfd_pkg::A0_W'(1) << (gfd_pkg::SCALE_SH - 1))) >> gfd_pkg::SCALE_SH);
		end
	end

	assign out_vld = vld_q[gfd_pkg::HORN_LAT-1];
	assign scale   = scale_s7;

endmodule

`default_nettype wire

### rtl/core/gfd_isqrt.sv
// ----------------------------------------------------------------------------
// gfd_isqrt: pipelined floor integer square root
// One root bit per stage, restoring form, valid bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gfd_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_vld,
	input  wire logic [gfd_pkg::RAD_W-1:0]   rad,
	output logic                             out_vld,
	output logic      [gfd_pkg::ROOT_W-1:0]  root
);

	logic [gfd_pkg::ROOT_W-1:0] vld_s;
	logic [gfd_pkg::REM_W-1:0]  rem_s  [gfd_pkg::ROOT_W];
	logic [gfd_pkg::ROOT_W-1:0] root_s [gfd_pkg::ROOT_W];
	logic [gfd_pkg::RAD_W-1:0]  rad_s  [gfd_pkg::ROOT_W];
	logic [gfd_pkg::REM_W-1:0]  rem_n  [gfd_pkg::ROOT_W];
	logic [gfd_pkg::ROOT_W-1:0] root_n [gfd_pkg::ROOT_W];
	logic [gfd_pkg::RAD_W-1:0]  rad_n  [gfd_pkg::ROOT_W];

	always_comb begin
		logic [gfd_pkg::REM_W-1:0]  p_rem;
		logic [gfd_pkg::ROOT_W-1:0] p_root;
		logic [gfd_pkg::RAD_W-1:0]  p_rad;
		logic [gfd_pkg::REM_W-1:0]  cand;
		logic [gfd_pkg::REM_W-1:0]  trial;
		for (int k = 0; k < gfd_pkg::ROOT_W; k++) begin
			if (k == 0) begin
				p_rem  = '0;
				p_root = '0;
				p_rad  = rad;
			end else begin
				p_rem  = rem_s[k-1];
				p_root = root_s[k-1];
				p_rad  = rad_s[k-1];
			end
			// bring down the next radicand pair, try root*4 + 1
			cand  = {p_rem[gfd_pkg::REM_W-3:0], p_rad[gfd_pkg::RAD_W-1 -: 2]};
			trial = {1'b0, p_root, 2'b01};
			if (cand >= trial) begin
				rem_n[k]  = cand - trial;
				root_n[k] = {p_root[gfd_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_n[k]  = cand;
				root_n[k] = {p_root[gfd_pkg::ROOT_W-2:0], 1'b0};
			end
			rad_n[k] = {p_rad[gfd_pkg::RAD_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[gfd_pkg::ROOT_W-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < gfd_pkg::ROOT_W; k++) begin
			rem_s[k]  <= rem_n[k];
			root_s[k] <= root_n[k];
			rad_s[k]  <= rad_n[k];
		end
	end

	assign out_vld = vld_s[gfd_pkg::ROOT_W-1];
	assign root    = root_s[gfd_pkg::ROOT_W-1];

endmodule

`default_nettype wire

### rtl/core/gfd_checker.sv
// ----------------------------------------------------------------------------
// gfd_checker: port-level checks for geographic_flat_distance
// Fixed latency, no back-pressure and zero distance for coincident points.
// ----------------------------------------------------------------------------
`default_nettype none

module gfd_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic signed [gfd_pkg::LON_W-1:0]  event_lon,
	input wire logic signed [gfd_pkg::LAT_W-1:0]  event_lat,
	input wire logic signed [gfd_pkg::LON_W-1:0]  station_lon,
	input wire logic signed [gfd_pkg::LAT_W-1:0]  station_lat,
	input wire logic                              done,
	input wire logic        [gfd_pkg::DIST_W-1:0] distance_km
);

	localparam int CNT_W = $clog2(gfd_pkg::GFD_LAT + 1);

	logic [CNT_W-1:0] age_q;
	logic             warm;

	// Count edges since reset release, hold at the pipeline latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (!warm) begin
			age_q <= age_q + CNT_W'(1);
		end
	end

	assign warm = (age_q == CNT_W'(gfd_pkg::GFD_LAT));

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised on a fully pipelined datapath");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, gfd_pkg::GFD_LAT)))
		else $error("done does not follow a transfer by the pipeline latency");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!warm |-> !done)
		else $error("done raised before any transfer could pass the pipeline");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && $past(start && !busy && event_lon == station_lon
			&& event_lat == station_lat, gfd_pkg::GFD_LAT)) |-> (distance_km == '0))
		else $error("coincident points give a nonzero distance");

endmodule

bind geographic_flat_distance gfd_checker u_gfd_checker (.*);

`default_nettype wire
